[rtl/brl_pkg.sv]
// ----------------------------------------------------------------------------
// brl_pkg: shared types for the line rasterizer
// Holds the sequencer state type used by the rasterizer top level.
// ----------------------------------------------------------------------------
package brl_pkg;

   typedef enum logic [1:0] {
      BRL_IDLE,
      BRL_SETUP,
      BRL_EMIT
   } brl_state_type;

endpackage

[rtl/brl_err_unit.sv]
// ----------------------------------------------------------------------------
// brl_err_unit: error term update for one step along the major axis
// Subtracts twice the minor extent from the doubled error term and, when the
// result goes negative, flags a minor-axis step and adds back twice the major
// extent.
// ----------------------------------------------------------------------------
module brl_err_unit #(
   parameter int COORD_BITS = 6
) (
   input  logic signed [COORD_BITS+2:0] err,
   input  logic        [COORD_BITS:0]   dx2,
   input  logic        [COORD_BITS:0]   dy2,
   output logic signed [COORD_BITS+2:0] err_next,
   output logic                         step
);

   logic signed [COORD_BITS+2:0] diff;

   always_comb begin
      diff     = err - $signed({2'b00, dy2});
      step     = diff[COORD_BITS+2];
      err_next = step ? diff + $signed({2'b00, dx2}) : diff;
   end

endmodule

[rtl/bresenham_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer: integer line stepping over a square tile
// Takes two endpoints per request and streams the pixels of the line.
// ----------------------------------------------------------------------------
// One request is taken while the block is idle; it then does setup in the
// SETUP state (axis swap for steep lines, endpoint ordering, extents) and
// emits the pixels from the EMIT state, holding whenever the result side
// stalls. The error-term unit is used once per emitted pixel. The final
// endpoint is not emitted. A line whose endpoints coincide yields one result
// with zero coordinates, tlast and tuser set. req_tready is high only while
// idle; the last result may still wait in the output register while the next
// request is taken.
module bresenham_line_rasterizer #(
   parameter int COORD_BITS = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // start_x, start_y, end_x, end_y, zero fill
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // point_x, point_y, zero fill
   output logic [((2*COORD_BITS+7)/8)*8-1:0]      rsp_tdata,
   // last_point
   output logic                                   rsp_tlast,
   // no_point
   output logic                                   rsp_tuser
);

   localparam int CB     = COORD_BITS;
   localparam int OUT_W  = ((2*COORD_BITS+7)/8)*8;
   localparam int EB     = COORD_BITS + 3;

   brl_pkg::brl_state_type state_ff, state_in;

   logic [CB-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [CB-1:0] ax_in, ay_in, bx_in, by_in;
   logic [CB-1:0] x_ff, x_in, y_ff, y_in, xlast_ff, xlast_in;
   logic [CB:0]   dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic signed [EB-1:0] err_ff, err_in;
   logic steep_ff, steep_in, ydown_ff, ydown_in, empty_ff, empty_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]     px_ff, px_in, py_ff, py_in;
   logic              last_ff, last_in, nop_ff, nop_in;

   logic signed [EB-1:0] err_next;
   logic                 err_step;

   // setup terms
   logic [CB-1:0] adx, ady;
   logic          steep_c;
   logic [CB-1:0] a_maj, a_min, b_maj, b_min;
   logic [CB-1:0] o_a_maj, o_a_min, o_b_maj, o_b_min;
   logic [CB-1:0] dx_c, dy_c;
   logic          out_free, is_last;

   brl_err_unit #(
      .COORD_BITS(COORD_BITS)
   ) u_err (
      .err      (err_ff),
      .dx2      (dx2_ff),
      .dy2      (dy2_ff),
      .err_next (err_next),
      .step     (err_step)
   );

   always_comb begin
      adx     = (bx_ff > ax_ff) ? bx_ff - ax_ff : ax_ff - bx_ff;
      ady     = (by_ff > ay_ff) ? by_ff - ay_ff : ay_ff - by_ff;
      steep_c = ady > adx;
      a_maj   = steep_c ? ay_ff : ax_ff;
      a_min   = steep_c ? ax_ff : ay_ff;
      b_maj   = steep_c ? by_ff : bx_ff;
      b_min   = steep_c ? bx_ff : by_ff;
      if (a_maj > b_maj) begin
         o_a_maj = b_maj;
         o_a_min = b_min;
         o_b_maj = a_maj;
         o_b_min = a_min;
      end else begin
         o_a_maj = a_maj;
         o_a_min = a_min;
         o_b_maj = b_maj;
         o_b_min = b_min;
      end
      dx_c = o_b_maj - o_a_maj;
      dy_c = (o_b_min > o_a_min) ? o_b_min - o_a_min : o_a_min - o_b_min;
   end

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      xlast_in     = xlast_ff;
      dx2_in       = dx2_ff;
      dy2_in       = dy2_ff;
      err_in       = err_ff;
      steep_in     = steep_ff;
      ydown_in     = ydown_ff;
      empty_in     = empty_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;
      nop_in       = nop_ff;
      out_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      is_last      = x_ff == xlast_ff;
      req_tready   = 1'b0;

      unique case (state_ff)
         brl_pkg::BRL_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ax_in    = req_tdata[CB-1:0];
               ay_in    = req_tdata[2*CB-1:CB];
               bx_in    = req_tdata[3*CB-1:2*CB];
               by_in    = req_tdata[4*CB-1:3*CB];
               state_in = brl_pkg::BRL_SETUP;
            end
         end
         brl_pkg::BRL_SETUP: begin
            x_in     = o_a_maj;
            y_in     = o_a_min;
            xlast_in = o_b_maj - {{(CB-1){1'b0}}, 1'b1};
            dx2_in   = {dx_c, 1'b0};
            dy2_in   = {dy_c, 1'b0};
            err_in   = $signed({3'b000, dx_c});
            steep_in = steep_c;
            ydown_in = !(o_a_min < o_b_min);
            empty_in = dx_c == '0;
            state_in = brl_pkg::BRL_EMIT;
         end
         brl_pkg::BRL_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (empty_ff) begin
                  px_in    = '0;
                  py_in    = '0;
                  last_in  = 1'b1;
                  nop_in   = 1'b1;
                  state_in = brl_pkg::BRL_IDLE;
               end else begin
                  px_in   = steep_ff ? y_ff : x_ff;
                  py_in   = steep_ff ? x_ff : y_ff;
                  last_in = is_last;
                  nop_in  = 1'b0;
                  x_in    = x_ff + {{(CB-1){1'b0}}, 1'b1};
                  err_in  = err_next;
                  if (err_step) begin
                     y_in = ydown_ff ? y_ff - {{(CB-1){1'b0}}, 1'b1}
                                     : y_ff + {{(CB-1){1'b0}}, 1'b1};
                  end
                  if (is_last) begin
                     state_in = brl_pkg::BRL_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = brl_pkg::BRL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brl_pkg::BRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      bx_ff    <= bx_in;
      by_ff    <= by_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      xlast_ff <= xlast_in;
      dx2_ff   <= dx2_in;
      dy2_ff   <= dy2_in;
      err_ff   <= err_in;
      steep_ff <= steep_in;
      ydown_ff <= ydown_in;
      empty_ff <= empty_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      last_ff  <= last_in;
      nop_ff   <= nop_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(OUT_W-2*CB){1'b0}}, py_ff, px_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = nop_ff;

endmodule

[tb/sv/bresenham_line_rasterizer_tb.sv]
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_tb: self-checking bench for the line rasterizer
// Streams endpoint pairs into the block and checks every emitted pixel, in
// order, against a behavioral line stepper in the bench or the stored result
// of a typed table row. A short table of corner lines runs first, then random
// lines of mixed length, under bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_tb;

   localparam int COORD_BITS    = 6;
   localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
   localparam int RANDOM_LINES  = 180;
   localparam int IDLE_LIMIT    = 4000;
   localparam int HOLD_OFF_LEN  = 400;
   localparam int DRAIN_CYCLES  = 2 * COORD_MAX + 8;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      logic      last_point;
      logic      no_point;
   } pixel_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      logic      typed;
      pixel_type only_pixel;
   } line_case_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC
   } ready_pattern_type;

   localparam pixel_type EMPTY_LINE  =
      '{point_x: '0, point_y: '0, last_point: 1'b1, no_point: 1'b1};
   localparam pixel_type ORIGIN_LAST =
      '{point_x: '0, point_y: '0, last_point: 1'b1, no_point: 1'b0};
   localparam pixel_type UNTYPED     = '0;

   // rows with typed == 1 carry their single result; the rest go through the stepper
   localparam int DIRECTED_COUNT = 20;
   localparam line_case_type DIRECTED_LINES [DIRECTED_COUNT] = '{
      '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1, EMPTY_LINE},
      '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1, EMPTY_LINE},
      '{6'd42, 6'd21, 6'd42, 6'd21, 1'b1, EMPTY_LINE},
      '{6'd0,  6'd0,  6'd1,  6'd0,  1'b1, ORIGIN_LAST},
      '{6'd0,  6'd0,  6'd0,  6'd1,  1'b1, ORIGIN_LAST},
      '{6'd0,  6'd0,  6'd1,  6'd1,  1'b1, ORIGIN_LAST},
      '{6'd0,  6'd0,  6'd63, 6'd0,  1'b0, UNTYPED},
      '{6'd63, 6'd0,  6'd0,  6'd0,  1'b0, UNTYPED},
      '{6'd0,  6'd0,  6'd0,  6'd63, 1'b0, UNTYPED},
      '{6'd0,  6'd63, 6'd0,  6'd0,  1'b0, UNTYPED},
      '{6'd0,  6'd0,  6'd63, 6'd63, 1'b0, UNTYPED},
      '{6'd63, 6'd63, 6'd0,  6'd0,  1'b0, UNTYPED},
      '{6'd0,  6'd63, 6'd63, 6'd0,  1'b0, UNTYPED},
      '{6'd63, 6'd0,  6'd0,  6'd63, 1'b0, UNTYPED},
      '{6'd10, 6'd5,  6'd12, 6'd40, 1'b0, UNTYPED},
      '{6'd5,  6'd10, 6'd40, 6'd12, 1'b0, UNTYPED},
      '{6'd5,  6'd40, 6'd40, 6'd12, 1'b0, UNTYPED},
      '{6'd40, 6'd5,  6'd12, 6'd60, 1'b0, UNTYPED},
      '{6'd21, 6'd42, 6'd42, 6'd21, 1'b0, UNTYPED},
      '{6'd1,  6'd1,  6'd0,  6'd0,  1'b0, UNTYPED}
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   pixel_type pending_pixels [$];
   int     error_count    = 0;
   int     lines_sent     = 0;
   int     empty_lines    = 0;
   int     pixels_checked = 0;
   int     burst_left     = 0;
   int     hold_off_requests = 0;
   int     hold_offs_served  = 0;

   bresenham_line_rasterizer #(
      .COORD_BITS(COORD_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // appends one pixel at the tail of the expected queue
   function automatic void queue_pixel(input pixel_type pix);
      pending_pixels.insert(pending_pixels.size(), pix);
   endfunction

   // steps the major axis with a doubled integer error and queues each pixel
   function automatic void rasterize_line(input coord_type sx, input coord_type sy,
                                          input coord_type ex, input coord_type ey);
      int        ax, ay, bx, by, t, adx, ady, dx, dy, ystep, err, x, y;
      bit        steep;
      pixel_type pix;
      ax  = sx;
      ay  = sy;
      bx  = ex;
      by  = ey;
      adx = (bx > ax) ? bx - ax : ax - bx;
      ady = (by > ay) ? by - ay : ay - by;
      steep = ady > adx;
      if (steep) begin
         t = ax; ax = ay; ay = t;
         t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      dx    = bx - ax;
      dy    = (by > ay) ? by - ay : ay - by;
      ystep = (ay < by) ? 1 : -1;
      if (dx == 0) begin
         queue_pixel(EMPTY_LINE);
         return;
      end
      err = dx;
      y   = ay;
      for (x = ax; x < bx; x++) begin
         pix.point_x    = steep ? coord_type'(y) : coord_type'(x);
         pix.point_y    = steep ? coord_type'(x) : coord_type'(y);
         pix.last_point = (x == bx - 1);
         pix.no_point   = 1'b0;
         queue_pixel(pix);
         err -= 2 * dy;
         if (err < 0) begin
            y   += ystep;
            err += 2 * dx;
         end
      end
   endfunction

   function automatic coord_type clamp_coord(input int value);
      if (value < 0)
         return '0;
      if (value > COORD_MAX)
         return coord_type'(COORD_MAX);
      return coord_type'(value);
   endfunction

   // offers one line at this falling edge; returns at a falling edge after the take and any gap
   task automatic send_line(input coord_type sx, input coord_type sy,
                            input coord_type ex, input coord_type ey,
                            input logic typed, input pixel_type only_pixel);
      int gap;
      req_tvalid = 1'b1;
      req_tdata  = {ey, ex, sy, sx};
      do
         @(posedge clock);
      while (!req_tready);
      if (typed)
         queue_pixel(only_pixel);
      else
         rasterize_line(sx, sy, ex, ey);
      lines_sent++;
      if (sx == ex && sy == ey)
         empty_lines++;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end else begin
         burst_left--;
      end
   endtask

   // result side: a pattern that changes now and then, plus a long hold-off on request
   always @(negedge clock) begin : result_stall
      static int                pattern_left = 0;
      static int                hold_off_left = 0;
      static int                stall_cycle = 0;
      static ready_pattern_type pattern = READY_ALWAYS;
      stall_cycle++;
      if (hold_off_requests != hold_offs_served) begin
         hold_offs_served = hold_off_requests;
         hold_off_left    = HOLD_OFF_LEN;
      end
      if (pattern_left == 0) begin
         pattern      = ready_pattern_type'($urandom_range(0, 2));
         pattern_left = $urandom_range(20, 150);
      end else begin
         pattern_left--;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready = 1'b0;
      end else begin
         case (pattern)
            READY_ALWAYS:   rsp_tready = 1'b1;
            READY_RANDOM:   rsp_tready = ($urandom_range(0, 2) != 0);
            READY_PERIODIC: rsp_tready = ((stall_cycle % 5) < 2);
            default:        rsp_tready = 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin : pixel_check
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d last=%0b empty=%0b",
                   rsp_tdata[5:0], rsp_tdata[11:6], rsp_tlast, rsp_tuser);
            error_count++;
         end else begin
            want = pending_pixels[0];
            pending_pixels.delete(0);
            pixels_checked++;
            if (rsp_tdata[5:0] !== want.point_x) begin
               $error("point_x: expected %0d, got %0d", want.point_x, rsp_tdata[5:0]);
               error_count++;
            end
            if (rsp_tdata[11:6] !== want.point_y) begin
               $error("point_y: expected %0d, got %0d", want.point_y, rsp_tdata[11:6]);
               error_count++;
            end
            if (rsp_tlast !== want.last_point) begin
               $error("last_point: expected %0b, got %0b", want.last_point, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser !== want.no_point) begin
               $error("no_point: expected %0b, got %0b", want.no_point, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      static int idle_cycles = 0;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d cycles without a transfer, %0d pixels pending",
                     idle_cycles, pending_pixels.size());
            $display("bresenham_line_rasterizer_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      coord_type sx, sy, ex, ey;
      int        kind;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_line(DIRECTED_LINES[i].start_x, DIRECTED_LINES[i].start_y,
                   DIRECTED_LINES[i].end_x, DIRECTED_LINES[i].end_y,
                   DIRECTED_LINES[i].typed, DIRECTED_LINES[i].only_pixel);
      end

      for (int i = 0; i < RANDOM_LINES; i++) begin
         // long output hold-off while requests keep coming back to back
         if (i == 60) begin
            hold_off_requests++;
            burst_left = 12;
         end
         // let everything drain before going on
         if (i == 120) begin
            req_tvalid = 1'b0;
            while (pending_pixels.size() != 0)
               @(negedge clock);
         end
         sx   = coord_type'($urandom_range(0, COORD_MAX));
         sy   = coord_type'($urandom_range(0, COORD_MAX));
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            ex = sx;
            ey = sy;
         end else if (kind <= 3) begin
            ex = clamp_coord(int'(sx) + $urandom_range(0, 8) - 4);
            ey = clamp_coord(int'(sy) + $urandom_range(0, 8) - 4);
         end else if (kind == 4) begin
            ex = $urandom_range(0, 1) ? sx : coord_type'($urandom_range(0, COORD_MAX));
            ey = (ex == sx) ? coord_type'($urandom_range(0, COORD_MAX)) : sy;
         end else begin
            ex = coord_type'($urandom_range(0, COORD_MAX));
            ey = coord_type'($urandom_range(0, COORD_MAX));
         end
         send_line(sx, sy, ex, ey, 1'b0, UNTYPED);
      end

      req_tvalid = 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d lines (%0d empty), %0d pixels checked, with bursty requests,",
               lines_sent, empty_lines, pixels_checked);
      $display("a long output hold-off and a full drain pause; %0d mismatches", error_count);
      if (error_count == 0) begin
         $display("bresenham_line_rasterizer_tb: PASS");
      end else begin
         $display("bresenham_line_rasterizer_tb: FAIL");
      end
      $finish;
   end

endmodule
